>>> rtl/core/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter:
// field widths, the sequencer states and the datapath command codes.
// ----------------------------------------------------------------------------
package bda_pkg;

   // field widths
   localparam int VALUE_W   = 32;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 6;
   localparam int COUNT_W   = 4;
   localparam int BIT_CNT_W = $clog2(VALUE_W);

   // largest number of decimal digits a 32-bit value can have
   localparam int HW_DIGITS = 10;

   // ascii '0' kept to the six bits of the character field
   localparam logic [CHAR_W-1:0] ZERO_CHAR = CHAR_W'(48);

   // index of the first input bit shifted into the bcd register
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } bda_state_type;

   // datapath commands
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_DABBLE,
      CMD_SHIFT
   } bda_cmd_type;

   // datapath status back to the sequencer
   typedef struct packed {
      logic [DIGIT_W-1:0] top_digit;
      logic               overflow;
   } bda_status_type;

endpackage

>>> rtl/core/bda_dabble.sv
// ----------------------------------------------------------------------------
// bda_dabble
// Shift-and-add-3 datapath: moves the binary value into a bcd register one
// bit per cycle, then shifts the finished digits out from the top.
// ----------------------------------------------------------------------------
module bda_dabble #(
   parameter int NUM_DIGITS = 10
) (
   input  logic                            clock,
   input  bda_pkg::bda_cmd_type            cmd,
   input  logic [bda_pkg::VALUE_W-1:0]     value,
   output bda_pkg::bda_status_type         status
);
   import bda_pkg::*;

   localparam int BCD_W = NUM_DIGITS * DIGIT_W;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               ovf_ff, ovf_in;
   logic [BCD_W-1:0]   adjusted;

   // add 3 to every digit of 5 or more ahead of the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // next values per command
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      unique case (cmd)
         CMD_LOAD: begin
            bin_in = value;
            bcd_in = '0;
            ovf_in = 1'b0;
         end
         CMD_DABBLE: begin
            bin_in = bin_ff << 1;
            bcd_in = {adjusted[BCD_W-2:0], bin_ff[VALUE_W-1]};
            // a bit leaving the top digit means more digits than the window
            ovf_in = ovf_ff | adjusted[BCD_W-1];
         end
         CMD_SHIFT: begin
            bcd_in = bcd_ff << DIGIT_W;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
   end

   assign status.top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign status.overflow  = ovf_ff;

endmodule

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned 32-bit number to its decimal ASCII digits, most
// significant first, without leading zeros.
// ----------------------------------------------------------------------------
// Each request is turned into bcd by shift-and-add-3 steps, one input bit per
// cycle. Leading zero digits are then dropped one per cycle and the
// remaining digits are sent one per cycle while the result channel accepts
// them, the last one marked by tlast and every one carrying the total digit
// count. With a ready sink the time from one accept to the next depends on
// the digit window (MAX_DIGITS, capped at 10) but not on the value, since the
// bcd register is filled bit-serially.
// Only one request is in flight; a new one is accepted while the last digit
// of the previous one still waits in the output register. MAX_DIGITS below
// 10 keeps only that many low digits of larger values.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] digit_char, [9:6] digit_count, [15:10] zero
   output logic        rsp_tlast    // last_digit
);
   import bda_pkg::*;

   localparam int NUM_DIGITS = (MAX_DIGITS > HW_DIGITS) ? HW_DIGITS :
                               ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam logic [COUNT_W-1:0] WINDOW_COUNT = COUNT_W'(NUM_DIGITS);
   localparam logic [COUNT_W-1:0] ONE_COUNT    = COUNT_W'(1);

   bda_state_type             state_ff, state_in;
   bda_cmd_type               cmd;
   bda_status_type            status;
   logic [BIT_CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]        remain_ff, remain_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      req_accept;
   logic                      skip_digit;
   logic                      out_free;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // drop a leading zero while more than one digit remains and nothing overflowed
   assign skip_digit = !status.overflow && (status.top_digit == '0) && (remain_ff > ONE_COUNT);

   // bcd datapath
   bda_dabble #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock  (clock),
      .cmd    (cmd),
      .value  (req_tdata),
      .status (status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_digit) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && remain_ff == ONE_COUNT) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) cmd = CMD_LOAD;
         end
         ST_CONVERT: cmd = CMD_DABBLE;
         ST_SKIP: begin
            if (skip_digit) cmd = CMD_SHIFT;
         end
         ST_EMIT: begin
            if (out_free) cmd = CMD_SHIFT;
         end
         default: begin
         end
      endcase
   end

   // counters and output register
   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            bit_cnt_in = BIT_LAST;
         end
         ST_CONVERT: begin
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            remain_in  = WINDOW_COUNT;
         end
         ST_SKIP: begin
            if (skip_digit) begin
               remain_in = remain_ff - ONE_COUNT;
            end else begin
               count_in = remain_ff;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ZERO_CHAR | CHAR_W'(status.top_digit);
               rsp_count_in = count_ff;
               rsp_last_in  = (remain_ff == ONE_COUNT);
               remain_in    = remain_ff - ONE_COUNT;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // counters and result payload
   always_ff @(posedge clock) begin
      bit_cnt_ff   <= bit_cnt_in;
      remain_ff    <= remain_in;
      count_ff     <= count_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_decimal_ascii_unit. A short table of
// directed values (zero, single digits, decade edges, the 32-bit maximum)
// runs first, then a few hundred random values spread over all digit
// lengths. Every request without typed digit text is turned into its expected
// digit stream by a division-by-ten model in the bench, and each digit taken
// from the result channel is compared field by field with the oldest expected
// one. Both channels idle in random bursts, and the result side holds off once
// for a long stretch so that the unit backs up and stalls its request channel.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bda_pkg::*;

   // one expected result beat
   typedef struct packed {
      logic [CHAR_W-1:0]  digit_char;
      logic [COUNT_W-1:0] digit_count;
      logic               last_digit;
   } digit_beat_type;

   localparam int  DIR_ROWS      = 22;
   localparam int  RANDOM_VALUES = 450;
   localparam int  CALM_VALUES   = 60;
   localparam int  LONG_HOLD     = 600;
   localparam int  DRAIN_CYCLES  = 3 * (HW_DIGITS + 34);
   localparam int  CYCLE_LIMIT   = 800000;
   localparam int  REPORT_MAX    = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [5:0] digit_char, [9:6] digit_count, [15:10] zero
   logic        rsp_tlast;   // last_digit

   digit_beat_type pending_digits[$];
   digit_beat_type seen_beat;
   int             mismatch_count;
   int             cycle_count;
   bit             idling_on;
   bit             long_hold_req;

   // directed values; a text entry is the digit string read off directly,
   // an empty entry leaves the value to the division model
   logic [31:0] dir_value [DIR_ROWS] = '{
      32'd0, 32'd4294967295, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
      32'd999999999, 32'd1000000000, 32'd1234567890, 32'd4000000000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hDEAD_BEEF, 32'h0000_FFFF, 32'd7, 32'd4294967294, 32'd101,
      32'h1234_5678, 32'd3999999999
   };
   string dir_text [DIR_ROWS] = '{
      "0", "4294967295", "1", "9", "10", "99", "100",
      "999999999", "1000000000", "1234567890", "4000000000",
      "", "", "", "", "", "", "", "", "", "", ""
   };

   binary_to_decimal_ascii_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // expected digits of a value, most significant first
   function automatic void queue_decimal_digits(input logic [31:0] value);
      logic [DIGIT_W-1:0] digits [HW_DIGITS];
      logic [31:0]        rest;
      int                 n;
      digit_beat_type     beat;
      rest = value;
      n    = 0;
      do begin
         digits[n] = DIGIT_W'(rest % 32'd10);
         n++;
         rest = rest / 32'd10;
      end while (rest != 32'd0);
      for (int k = 0; k < n; k++) begin
         beat.digit_char  = ZERO_CHAR + CHAR_W'(digits[n - 1 - k]);
         beat.digit_count = COUNT_W'(n);
         beat.last_digit  = (k == n - 1);
         pending_digits.push_back(beat);
      end
   endfunction

   // expected digits typed in as text
   function automatic void queue_digit_text(input string text);
      digit_beat_type beat;
      for (int k = 0; k < text.len(); k++) begin
         beat.digit_char  = CHAR_W'(text.getc(k));
         beat.digit_count = COUNT_W'(text.len());
         beat.last_digit  = (k == text.len() - 1);
         pending_digits.push_back(beat);
      end
   endfunction

   // typed text wins where it is given
   function automatic void queue_decimal_digits_or_text(input logic [31:0] value,
                                                        input string text);
      if (text.len() != 0)
         queue_digit_text(text);
      else
         queue_decimal_digits(value);
   endfunction

   function automatic void note_mismatch(input string what, input int exp_val,
                                         input int got_val);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch %0s: expected %0d, got %0d", what, exp_val, got_val);
   endfunction

   // random value: full range, a chosen digit length, near a power of ten,
   // or a small number
   function automatic logic [31:0] random_value();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned pow;
      int              len;
      logic [31:0]     value;
      case ($urandom_range(0, 3))
         0: begin
            value = $urandom;
         end
         1: begin
            len = $urandom_range(1, HW_DIGITS);
            pow = 1;
            for (int k = 1; k < len; k++) pow = pow * 10;
            lo = (len == 1) ? 0 : pow;
            hi = pow * 10 - 1;
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            value = $urandom_range(32'(hi), 32'(lo));
         end
         2: begin
            pow = 1;
            len = $urandom_range(0, HW_DIGITS - 1);
            for (int k = 0; k < len; k++) pow = pow * 10;
            value = 32'(pow) + 32'($urandom_range(0, 4)) - 32'd2;
         end
         default: begin
            value = $urandom_range(0, 99);
         end
      endcase
      return value;
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_value(input logic [31:0] value, input string text);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queue_decimal_digits_or_text(value, text);
   endtask

   // random gap between requests, with junk on the data lines
   task automatic request_gap();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare each taken digit with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            note_mismatch("digit with nothing expected, char", 0,
                          int'(rsp_tdata[CHAR_W-1:0]));
         end else begin
            seen_beat = pending_digits.pop_front();
            if (rsp_tdata[CHAR_W-1:0] !== seen_beat.digit_char)
               note_mismatch("digit_char", int'(seen_beat.digit_char),
                             int'(rsp_tdata[CHAR_W-1:0]));
            if (rsp_tdata[CHAR_W+COUNT_W-1:CHAR_W] !== seen_beat.digit_count)
               note_mismatch("digit_count", int'(seen_beat.digit_count),
                             int'(rsp_tdata[CHAR_W+COUNT_W-1:CHAR_W]));
            if (rsp_tlast !== seen_beat.last_digit)
               note_mismatch("last_digit", int'(seen_beat.last_digit),
                             int'(rsp_tlast));
            if (rsp_tdata[15:CHAR_W+COUNT_W] !== '0)
               note_mismatch("tdata padding", 0,
                             int'(rsp_tdata[15:CHAR_W+COUNT_W]));
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus and verdict
   initial begin
      mismatch_count = 0;
      idling_on      = 1'b1;
      long_hold_req  = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         send_value(dir_value[r], dir_text[r]);
         request_gap();
      end

      // pause until every digit has come out
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);

      // result side holds off while requests keep coming
      long_hold_req = 1'b1;
      for (int k = 0; k < 8; k++) send_value($urandom, "");

      // random values, calm toward the end
      for (int k = 0; k < RANDOM_VALUES; k++) begin
         if (k == RANDOM_VALUES - CALM_VALUES) idling_on = 1'b0;
         send_value(random_value(), "");
         request_gap();
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray digits
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_digits.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
